// ===== hw/rtl/ppst_pkg.sv =====
`default_nettype none
package ppst_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_UPSERT   = 2'd0;
   localparam kind_type KIND_DELETE   = 2'd1;
   localparam kind_type KIND_SCHEDULE = 2'd2;
   localparam kind_type KIND_LOOKUP   = 2'd3;

   localparam logic CSR_MIN_POWER = 1'b0;
   localparam logic CSR_MAX_POWER = 1'b1;

   localparam logic signed [15:0] MIN_POWER_RESET = 16'sd0;
   localparam logic signed [15:0] MAX_POWER_RESET = 16'sd1000;

   localparam logic [3:0] PARTS_SAT = 4'd15;

   // one table slot as stored in the entry memory
   typedef struct packed {
      logic [63:0]        serial;
      logic [6:0]         charge;
      logic signed [15:0] request;
      logic signed [15:0] share;
      logic               allowed;
   } entry_type;

endpackage
`default_nettype wire

// ===== hw/rtl/proportional_power_share_table.sv =====
`default_nettype none
// Device power share table with a proportional scheduler.
//
// Request channel (req_*, valid/ready): one command per request: upsert,
// delete, schedule or lookup. Response channel (rsp_*, valid/ready): exactly
// one response per request, in order. csr_* writes min_power (index 0) and
// max_power (index 1); write them only while the block is idle.
//
// One request is worked at a time; req_ready is low from acceptance until
// the response is placed in the response register. Upsert, delete and lookup
// walk the entry memory, a read state and a use state per slot. Schedule walks
// the table once to sum, once more dividing each share on the shared serial
// divider, and then runs spread rounds of a count walk, one division and an
// apply walk each; the division unit and the single memory read port set
// the pace of these walks.
//
// Reset clears all slots to empty (per-slot occupancy flops) and loads the
// power bounds with 0 and 1000. A stalled receiver holds the response; the
// next request is still accepted and waits in its final state for the slot.
module proportional_power_share_table #(
   parameter int TABLE_DEPTH = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [63:0]        req_serial,
   input  wire logic [6:0]         req_charge_level,
   input  wire logic signed [15:0] req_requested_power,
   input  wire logic signed [15:0] req_initial_share,
   input  wire logic               req_allowed,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic [3:0]              rsp_participants,
   output logic signed [15:0]      rsp_share,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_wdata
);

   localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int SCW  = 7 + CW;
   localparam int SRW  = 16 + CW;
   localparam int DW   = SRW + 8;
   localparam int GW   = 18 + CW;
   localparam int EW   = $bits(ppst_pkg::entry_type);
   localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
   localparam int PARTS_SAT_INT = 15;

   typedef enum logic [17:0] {
      ST_IDLE     = 18'h00001,
      ST_FIND_RD  = 18'h00002,
      ST_FIND_USE = 18'h00004,
      ST_ACT      = 18'h00008,
      ST_S1_RD    = 18'h00010,
      ST_S1_USE   = 18'h00020,
      ST_P_RD     = 18'h00040,
      ST_P_USE    = 18'h00080,
      ST_P_START  = 18'h00100,
      ST_P_WAIT   = 18'h00200,
      ST_P_WR     = 18'h00400,
      ST_SP_BEGIN = 18'h00800,
      ST_C_RD     = 18'h01000,
      ST_C_USE    = 18'h02000,
      ST_SP_WAIT  = 18'h04000,
      ST_A_RD     = 18'h08000,
      ST_A_USE    = 18'h10000,
      ST_DONE     = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   logic [IW-1:0]             idx_ff, idx_in;
   ppst_pkg::kind_type        kind_ff, kind_in;
   logic [63:0]               serial_ff, serial_in;
   logic [6:0]                charge_ff, charge_in;
   logic signed [15:0]        req_ff, req_in;
   logic signed [15:0]        init_ff, init_in;
   logic                      allowed_ff, allowed_in;
   logic                      found_ff, found_in;
   logic [IW-1:0]             hit_idx_ff, hit_idx_in;
   logic                      empty_ok_ff, empty_ok_in;
   logic [IW-1:0]             empty_idx_ff, empty_idx_in;
   logic [SCW-1:0]            sum_charge_ff, sum_charge_in;
   logic signed [SRW-1:0]     sum_req_ff, sum_req_in;
   logic [CW-1:0]             n_ff, n_in;
   logic signed [GW-1:0]      gap_ff, gap_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic signed [GW-1:0]      step_ff, step_in;
   logic                      up_ff, up_in;
   ppst_pkg::entry_type       ent_ff, ent_in;
   logic signed [DW-1:0]      prod_ff, prod_in;
   logic                      res_ok_ff, res_ok_in;
   logic [3:0]                res_parts_ff, res_parts_in;
   logic signed [15:0]        res_share_ff, res_share_in;
   logic signed [15:0]        min_ff, max_ff;
   logic [TABLE_DEPTH-1:0]    occ_ff, occ_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff;
   logic [3:0]                rsp_parts_ff;
   logic signed [15:0]        rsp_share_ff;
   logic                      rsp_load;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   ppst_pkg::entry_type       wr_data;
   logic [EW-1:0]             rd_data;

   logic                      div_start;
   logic signed [DW-1:0]      div_dividend;
   logic [SCW-1:0]            div_divisor;
   logic                      div_done;
   logic signed [DW-1:0]      div_q;

   ppst_pkg::entry_type       ent;
   logic                      part, last, has_room;
   logic signed [16:0]        room;
   logic signed [GW-1:0]      gap_mag, delta;
   logic signed [15:0]        clamped;
   logic                      accept;

   ppst_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   ppst_div #(.DW(DW), .VW(SCW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // empty slots read as all zero whatever the memory holds
   assign ent  = occ_ff[idx_ff] ? ppst_pkg::entry_type'(rd_data) : '0;
   assign part = occ_ff[idx_ff] && ent.allowed;
   assign last = (idx_ff == LAST);

   // headroom of the slot on the port, in the current spread direction
   assign has_room = up_ff ? (ent.share < max_ff) : (ent.share > min_ff);
   assign room     = up_ff ? (17'(max_ff) - 17'(ent.share))
                           : (17'(ent.share) - 17'(min_ff));
   assign gap_mag  = up_ff ? gap_ff : -gap_ff;

   always_comb begin
      delta = GW'(room);
      if (step_ff < delta) delta = step_ff;
      if (gap_mag < delta) delta = gap_mag;
   end

   // first clamp tests the upper bound, then the lower
   always_comb begin
      if (div_q > DW'(max_ff)) begin
         clamped = max_ff;
      end else if (div_q < DW'(min_ff)) begin
         clamped = min_ff;
      end else begin
         clamped = div_q[15:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      serial_in     = serial_ff;
      charge_in     = charge_ff;
      req_in        = req_ff;
      init_in       = init_ff;
      allowed_in    = allowed_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      empty_ok_in   = empty_ok_ff;
      empty_idx_in  = empty_idx_ff;
      sum_charge_in = sum_charge_ff;
      sum_req_in    = sum_req_ff;
      n_in          = n_ff;
      gap_in        = gap_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      up_in         = up_ff;
      ent_in        = ent_ff;
      prod_in       = prod_ff;
      res_ok_in     = res_ok_ff;
      res_parts_in  = res_parts_ff;
      res_share_in  = res_share_ff;
      occ_in        = occ_ff;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = ent;
      div_start     = 1'b0;
      div_dividend  = prod_ff;
      div_divisor   = sum_charge_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_kind;
               serial_in     = req_serial;
               charge_in     = req_charge_level;
               req_in        = req_requested_power;
               init_in       = req_initial_share;
               allowed_in    = req_allowed;
               idx_in        = '0;
               found_in      = 1'b0;
               empty_ok_in   = 1'b0;
               sum_charge_in = '0;
               sum_req_in    = '0;
               n_in          = '0;
               res_ok_in     = 1'b0;
               res_parts_in  = '0;
               res_share_in  = '0;
               if (req_kind == ppst_pkg::KIND_SCHEDULE) begin
                  state_in = ST_S1_RD;
               end else if (req_serial == 64'd0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_FIND_RD: state_in = ST_FIND_USE;
         ST_FIND_USE: begin
            if (!occ_ff[idx_ff] && !empty_ok_ff) begin
               empty_ok_in  = 1'b1;
               empty_idx_in = idx_ff;
            end
            if (occ_ff[idx_ff] && ent.serial == serial_ff) begin
               found_in   = 1'b1;
               hit_idx_in = idx_ff;
               ent_in     = ent;
               state_in   = ST_ACT;
            end else if (last) begin
               state_in = ST_ACT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_FIND_RD;
            end
         end
         ST_ACT: begin
            state_in = ST_DONE;
            case (kind_ff)
               ppst_pkg::KIND_UPSERT: begin
                  wr_data.serial  = serial_ff;
                  wr_data.charge  = charge_ff;
                  wr_data.request = req_ff;
                  wr_data.allowed = allowed_ff;
                  if (found_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = hit_idx_ff;
                     wr_data.share = ent_ff.share;
                     res_ok_in     = 1'b1;
                  end else if (empty_ok_ff) begin
                     wr_en                = 1'b1;
                     wr_addr              = empty_idx_ff;
                     wr_data.share        = init_ff;
                     occ_in[empty_idx_ff] = 1'b1;
                     res_ok_in            = 1'b1;
                  end
               end
               ppst_pkg::KIND_DELETE: begin
                  if (found_ff) begin
                     occ_in[hit_idx_ff] = 1'b0;
                     res_ok_in          = 1'b1;
                  end
               end
               default: begin
                  if (found_ff) begin
                     res_ok_in    = 1'b1;
                     res_share_in = ent_ff.share;
                  end
               end
            endcase
         end
         ST_S1_RD: state_in = ST_S1_USE;
         ST_S1_USE: begin
            if (part) begin
               sum_charge_in = sum_charge_ff + SCW'(ent.charge);
               sum_req_in    = sum_req_ff + SRW'(ent.request);
               n_in          = n_ff + CW'(1);
            end else if (occ_ff[idx_ff]) begin
               wr_en         = 1'b1;
               wr_data.share = '0;
            end
            if (last) begin
               idx_in = '0;
               gap_in = GW'(sum_req_in);
               if (n_in == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_P_RD;
               end
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_S1_RD;
            end
         end
         ST_P_RD: state_in = ST_P_USE;
         ST_P_USE: begin
            if (part) begin
               ent_in   = ent;
               prod_in  = DW'(sum_req_ff) * DW'($signed({1'b0, ent.charge}));
               state_in = ST_P_START;
            end else if (last) begin
               state_in = ST_SP_BEGIN;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_P_RD;
            end
         end
         ST_P_START: begin
            div_start = 1'b1;
            if (sum_charge_ff == '0) begin
               div_dividend = DW'(sum_req_ff);
               div_divisor  = SCW'(n_ff);
            end
            state_in = ST_P_WAIT;
         end
         ST_P_WAIT: begin
            if (div_done) state_in = ST_P_WR;
         end
         ST_P_WR: begin
            wr_en         = 1'b1;
            wr_data       = ent_ff;
            wr_data.share = clamped;
            gap_in        = gap_ff - GW'(clamped);
            if (last) begin
               state_in = ST_SP_BEGIN;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_P_RD;
            end
         end
         ST_SP_BEGIN: begin
            if (gap_ff == '0) begin
               res_ok_in    = 1'b1;
               res_parts_in = (32'(n_ff) > 32'(PARTS_SAT_INT)) ? ppst_pkg::PARTS_SAT
                                                               : 4'(n_ff);
               state_in     = ST_DONE;
            end else begin
               up_in    = !gap_ff[GW-1];
               cnt_in   = '0;
               idx_in   = '0;
               state_in = ST_C_RD;
            end
         end
         ST_C_RD: state_in = ST_C_USE;
         ST_C_USE: begin
            if (part && has_room) cnt_in = cnt_ff + CW'(1);
            if (last) begin
               if (cnt_in == '0) begin
                  // no headroom left: drop the leftover
                  res_ok_in    = 1'b1;
                  res_parts_in = (32'(n_ff) > 32'(PARTS_SAT_INT)) ? ppst_pkg::PARTS_SAT
                                                                  : 4'(n_ff);
                  state_in     = ST_DONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = DW'(gap_mag);
                  div_divisor  = SCW'(cnt_in);
                  state_in     = ST_SP_WAIT;
               end
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_C_RD;
            end
         end
         ST_SP_WAIT: begin
            if (div_done) begin
               step_in  = (div_q == '0) ? GW'(1) : GW'(div_q);
               idx_in   = '0;
               state_in = ST_A_RD;
            end
         end
         ST_A_RD: state_in = ST_A_USE;
         ST_A_USE: begin
            if (part && has_room) begin
               wr_en = 1'b1;
               if (up_ff) begin
                  wr_data.share = 16'(17'(ent.share) + 17'(delta));
                  gap_in        = gap_ff - delta;
               end else begin
                  wr_data.share = 16'(17'(ent.share) - 17'(delta));
                  gap_in        = gap_ff + delta;
               end
            end
            if (last || gap_in == '0) begin
               state_in = ST_SP_BEGIN;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_A_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= ppst_pkg::MIN_POWER_RESET;
         max_ff       <= ppst_pkg::MAX_POWER_RESET;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               ppst_pkg::CSR_MIN_POWER: min_ff <= $signed(csr_wdata);
               ppst_pkg::CSR_MAX_POWER: max_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
      end
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      serial_ff     <= serial_in;
      charge_ff     <= charge_in;
      req_ff        <= req_in;
      init_ff       <= init_in;
      allowed_ff    <= allowed_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      empty_ok_ff   <= empty_ok_in;
      empty_idx_ff  <= empty_idx_in;
      sum_charge_ff <= sum_charge_in;
      sum_req_ff    <= sum_req_in;
      n_ff          <= n_in;
      gap_ff        <= gap_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      up_ff         <= up_in;
      ent_ff        <= ent_in;
      prod_ff       <= prod_in;
      res_ok_ff     <= res_ok_in;
      res_parts_ff  <= res_parts_in;
      res_share_ff  <= res_share_in;
      if (rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_parts_ff <= res_parts_ff;
         rsp_share_ff <= res_share_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_participants = rsp_parts_ff;
   assign rsp_share        = rsp_share_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ppst_ram.sv =====
`default_nettype none
module ppst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ppst_div.sv =====
`default_nettype none
// signed dividend over positive divisor, quotient truncated toward zero,
// one quotient bit per cycle
module ppst_div #(
   parameter int DW = 28,
   parameter int VW = 11
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [DW-1:0] dividend,
   input  wire logic [VW-1:0]        divisor,
   output logic                      done,
   output logic signed [DW-1:0]      quotient
);

   localparam int CTW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]   q_ff, q_in;
   logic [VW-1:0]   r_ff, r_in;
   logic [VW-1:0]   d_ff, d_in;
   logic            neg_ff, neg_in;
   logic [VW:0]     r_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      r_sh    = {r_ff, q_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CTW'(DW);
         q_in    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         r_in    = '0;
         d_in    = divisor;
         neg_in  = dividend[DW-1];
      end else if (busy_ff) begin
         if (r_sh >= {1'b0, d_ff}) begin
            r_in = VW'(r_sh - {1'b0, d_ff});
            q_in = {q_ff[DW-2:0], 1'b1};
         end else begin
            r_in = r_sh[VW-1:0];
            q_in = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CTW'(1);
         if (cnt_ff == CTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule
`default_nettype wire

// ===== hw/rtl/ppst_checker.sv =====
`default_nettype none
module ppst_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_ok,
   input wire logic [3:0]         rsp_participants,
   input wire logic signed [15:0] rsp_share
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_participants) && $stable(rsp_share))
      else $error("response changed while stalled");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after acceptance");

   // a failed request carries no share and no count
   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_share == 16'sd0 && rsp_participants == 4'd0)
      else $error("failed response with payload");

   // a share comes only from a lookup, which reports no participants
   a_share_vs_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_share != 16'sd0 |-> rsp_participants == 4'd0)
      else $error("share and participant count both set");

endmodule

bind proportional_power_share_table ppst_checker u_ppst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_ok           (rsp_ok),
   .rsp_participants (rsp_participants),
   .rsp_share        (rsp_share)
);
`default_nettype wire

// ===== test/proportional_power_share_table_test.sv =====
`timescale 1ns / 100ps
`default_nettype none

module proportional_power_share_table_test;

   localparam int DEPTH = 8;
   localparam int STALL_LIMIT = 100000;

   // Predicts responses from a private copy of the table and the power bounds.
   class share_scoreboard;
      typedef struct {
         bit              ok;
         bit [3:0]        parts;
         bit signed [15:0] share;
      } response_type;

      bit [63:0] slot_serial[DEPTH];
      bit [6:0]  slot_charge[DEPTH];
      int        slot_request[DEPTH];
      int        slot_share[DEPTH];
      bit        slot_allowed[DEPTH];
      int        lower_bound = 0;
      int        upper_bound = 1000;
      response_type pending[$];
      int        errors = 0;

      function int find_slot(bit [63:0] key);
         for (int i = 0; i < DEPTH; i++)
            if (slot_serial[i] == key) return i;
         return -1;
      endfunction

      function int run_schedule();
         int     map[DEPTH];
         int     n;
         longint sum_charge, sum_req, assigned, gap, s, cnt, step, d;
         bit     moved;
         n = 0; sum_charge = 0; sum_req = 0; assigned = 0;
         for (int i = 0; i < DEPTH; i++) begin
            if (slot_serial[i] != 0 && slot_allowed[i]) begin
               map[n++] = i;
               sum_charge += slot_charge[i];
               sum_req += slot_request[i];
            end else begin
               slot_share[i] = 0;
            end
         end
         if (n == 0) return 0;
         for (int k = 0; k < n; k++) begin
            s = (sum_charge > 0) ? (sum_req * longint'(slot_charge[map[k]])) / sum_charge
                                 : sum_req / n;
            if (s > upper_bound) s = upper_bound;
            else if (s < lower_bound) s = lower_bound;
            slot_share[map[k]] = int'(s);
            assigned += s;
         end
         gap = sum_req - assigned;
         while (gap != 0) begin
            moved = 0;
            cnt = 0;
            if (gap > 0) begin
               for (int k = 0; k < n; k++)
                  if (slot_share[map[k]] < upper_bound) cnt++;
               if (cnt == 0) break;
               step = gap / cnt;
               if (step == 0) step = 1;
               for (int k = 0; k < n && gap > 0; k++) begin
                  if (slot_share[map[k]] >= upper_bound) continue;
                  d = longint'(upper_bound) - slot_share[map[k]];
                  if (d > step) d = step;
                  if (d > gap) d = gap;
                  slot_share[map[k]] += int'(d);
                  gap -= d;
                  moved = 1;
               end
            end else begin
               for (int k = 0; k < n; k++)
                  if (slot_share[map[k]] > lower_bound) cnt++;
               if (cnt == 0) break;
               step = (-gap) / cnt;
               if (step == 0) step = 1;
               for (int k = 0; k < n && gap < 0; k++) begin
                  if (slot_share[map[k]] <= lower_bound) continue;
                  d = longint'(slot_share[map[k]]) - lower_bound;
                  if (d > step) d = step;
                  if (d > -gap) d = -gap;
                  slot_share[map[k]] -= int'(d);
                  gap += d;
                  moved = 1;
               end
            end
            if (!moved) break;
         end
         return n;
      endfunction

      function void set_bound(logic index, logic [15:0] value);
         if (index == ppst_pkg::CSR_MIN_POWER) lower_bound = $signed(value);
         else upper_bound = $signed(value);
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(ppst_pkg::kind_type kind, bit [63:0] key, bit [6:0] charge,
                                 bit signed [15:0] req_pwr, bit signed [15:0] init_share,
                                 bit allow);
         response_type r;
         int idx, n;
         r = '{0, 0, 0};
         case (kind)
            ppst_pkg::KIND_UPSERT: begin
               if (key != 0) begin
                  idx = find_slot(key);
                  if (idx < 0) begin
                     idx = find_slot(0);
                     if (idx >= 0) begin
                        slot_serial[idx] = key;
                        slot_share[idx] = init_share;
                     end
                  end
                  if (idx >= 0) begin
                     slot_charge[idx] = charge;
                     slot_request[idx] = req_pwr;
                     slot_allowed[idx] = allow;
                     r.ok = 1;
                  end
               end
            end
            ppst_pkg::KIND_DELETE: begin
               idx = (key != 0) ? find_slot(key) : -1;
               if (idx >= 0) begin
                  slot_serial[idx] = 0;
                  slot_charge[idx] = 0;
                  slot_request[idx] = 0;
                  slot_share[idx] = 0;
                  slot_allowed[idx] = 0;
                  r.ok = 1;
               end
            end
            ppst_pkg::KIND_SCHEDULE: begin
               n = run_schedule();
               r.ok = (n != 0);
               r.parts = (n > 15) ? ppst_pkg::PARTS_SAT : 4'(n);
            end
            default: begin
               idx = (key != 0) ? find_slot(key) : -1;
               if (idx >= 0) begin
                  r.ok = 1;
                  r.share = slot_share[idx][15:0];
               end
            end
         endcase
         pending.push_back(r);
      endfunction

      // Compare one response against the oldest queued prediction.
      function void check_response(bit ok, bit [3:0] parts, bit signed [15:0] share);
         response_type e;
         if (pending.size() == 0) begin
            $error("unexpected response ok=%0d participants=%0d share=%0d", ok, parts, share);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (ok !== e.ok) begin
            $error("ok: expected %0d, actual %0d", e.ok, ok);
            errors++;
         end
         if (parts !== e.parts) begin
            $error("participants: expected %0d, actual %0d", e.parts, parts);
            errors++;
         end
         if (share !== e.share) begin
            $error("share: expected %0d, actual %0d", e.share, share);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_kind = ppst_pkg::KIND_LOOKUP;
   logic [63:0]        req_serial = 0;
   logic [6:0]         req_charge_level = 0;
   logic signed [15:0] req_requested_power = 0;
   logic signed [15:0] req_initial_share = 0;
   logic               req_allowed = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic               rsp_ok;
   logic [3:0]         rsp_participants;
   logic signed [15:0] rsp_share;
   logic               csr_wr_en = 0;
   logic               csr_index = ppst_pkg::CSR_MIN_POWER;
   logic [15:0]        csr_wdata = 0;

   share_scoreboard board = new();
   int  sender_idle_pct = 0;     // chance per cycle that the sender holds off
   int  stall_pct = 0;           // chance per cycle that the receiver stalls
   int  accepts = 0;             // handshakes of either channel, feeds the watchdog
   int  requests_sent = 0;
   int  responses_seen = 0;
   int  schedules_sent = 0;
   bit [63:0] serial_pool[12];

   proportional_power_share_table #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_serial(req_serial), .req_charge_level(req_charge_level),
      .req_requested_power(req_requested_power), .req_initial_share(req_initial_share),
      .req_allowed(req_allowed),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_participants(rsp_participants), .rsp_share(rsp_share),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Receiver: pick ready on the falling edge, check on the rising edge.
   always @(negedge clock)
      rsp_ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_ok, rsp_participants, rsp_share);
         responses_seen++;
         accepts++;
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   int quiet_cycles = 0;
   int last_accepts = 0;
   always @(posedge clock) begin
      if (accepts != last_accepts || reset) begin
         quiet_cycles = 0;
         last_accepts = accepts;
      end else if (++quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake in %0d cycles", STALL_LIMIT);
         $display("proportional_power_share_table_test: errors");
         $finish;
      end
   end

   // Drive one request; hold it until the block takes it, then note it.
   task automatic send_request(ppst_pkg::kind_type kind, bit [63:0] key, bit [6:0] charge,
                               bit signed [15:0] req_pwr, bit signed [15:0] init_share,
                               bit allow);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_kind = kind;
      req_serial = key;
      req_charge_level = charge;
      req_requested_power = req_pwr;
      req_initial_share = init_share;
      req_allowed = allow;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, key, charge, req_pwr, init_share, allow);
      requests_sent++;
      accepts++;
      if (kind == ppst_pkg::KIND_SCHEDULE) schedules_sent++;
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a bound; only called with the block idle.
   task automatic write_bound(logic index, logic signed [15:0] value);
      @(negedge clock);
      csr_wr_en = 1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 0;
      board.set_bound(index, value);
   endtask

   task automatic random_request();
      int                 pick;
      ppst_pkg::kind_type kind;
      bit [63:0]          key;
      pick = $urandom_range(99);
      kind = (pick < 40) ? ppst_pkg::KIND_UPSERT : (pick < 55) ? ppst_pkg::KIND_DELETE :
             (pick < 75) ? ppst_pkg::KIND_SCHEDULE : ppst_pkg::KIND_LOOKUP;
      // Mostly reuse a small pool so updates, deletes and lookups hit.
      pick = $urandom_range(99);
      if (pick < 3) key = 0;
      else if (pick < 8) key = {$urandom, $urandom};
      else key = serial_pool[$urandom_range(11)];
      pick = $urandom_range(9);
      send_request(kind, key,
                   (pick == 0) ? 7'd0 : (pick == 1) ? 7'd100 : 7'($urandom_range(100)),
                   (pick < 3) ? 16'($urandom) : 16'($signed($urandom_range(1200)) - 200),
                   16'($urandom),
                   ($urandom_range(9) < 8));
   endtask

   initial begin
      for (int i = 0; i < 12; i++) serial_pool[i] = {$urandom, $urandom} | 64'd1;
      serial_pool[0] = '1;
      serial_pool[1] = 64'd1;
      serial_pool[2] = 64'h8000_0000_0000_0000;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: zero serial, empty table, fill, overflow, update, extremes.
      send_request(ppst_pkg::KIND_UPSERT, 0, 7'd50, 16'sd100, 16'sd0, 1);
      send_request(ppst_pkg::KIND_DELETE, 0, 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_SCHEDULE, 0, 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_LOOKUP, serial_pool[5], 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_DELETE, serial_pool[5], 0, 0, 0, 0);
      for (int i = 0; i < DEPTH; i++)
         send_request(ppst_pkg::KIND_UPSERT, serial_pool[i],
                      (i == 0) ? 7'd100 : 7'(i * 9),
                      (i == 1) ? -16'sd32768 : (i == 2) ? 16'sd32767 : 16'(i * 300),
                      (i == 3) ? -16'sd32768 : 16'sd32767, 1);
      send_request(ppst_pkg::KIND_UPSERT, serial_pool[9], 7'd10, 16'sd10, 16'sd5, 1);
      send_request(ppst_pkg::KIND_UPSERT, serial_pool[3], 7'd0, 16'sd700, 16'sd123, 1);
      send_request(ppst_pkg::KIND_LOOKUP, serial_pool[3], 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_SCHEDULE, '1, 7'd127, -16'sd1, -16'sd1, 1);
      send_request(ppst_pkg::KIND_LOOKUP, serial_pool[0], 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_UPSERT, serial_pool[4], 7'd0, 16'sd0, 16'sd0, 0);
      for (int i = 0; i < DEPTH; i++)
         if (i != 4)
            send_request(ppst_pkg::KIND_UPSERT, serial_pool[i], 7'd0, 16'sd500, 16'sd0, 1);
      send_request(ppst_pkg::KIND_SCHEDULE, 0, 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_LOOKUP, serial_pool[1], 0, 0, 0, 0);
      send_request(ppst_pkg::KIND_DELETE, serial_pool[1], 0, 0, 0, 0);
      drain();

      // Random phases: each one sets new bounds and the sender idling and receiver stall rates.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin write_bound(ppst_pkg::CSR_MIN_POWER, -16'sd32768);
                     write_bound(ppst_pkg::CSR_MAX_POWER, 16'sd32767); end
            1: begin write_bound(ppst_pkg::CSR_MIN_POWER, 16'sd500);
                     write_bound(ppst_pkg::CSR_MAX_POWER, -16'sd500); end
            2: begin write_bound(ppst_pkg::CSR_MIN_POWER, -16'sd200);
                     write_bound(ppst_pkg::CSR_MAX_POWER, 16'sd300); end
            3: begin write_bound(ppst_pkg::CSR_MIN_POWER, 16'sd32767);
                     write_bound(ppst_pkg::CSR_MAX_POWER, -16'sd32768); end
            default: begin
               write_bound(ppst_pkg::CSR_MIN_POWER, ppst_pkg::MIN_POWER_RESET);
               write_bound(ppst_pkg::CSR_MAX_POWER, ppst_pkg::MAX_POWER_RESET);
            end
         endcase
         sender_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase == 3) ? 26 : 48) : 0;
         stall_pct = (phase % 4 == 2) ? 48 : (phase == 3) ? 26 : 0;
         for (int n = 0; n < 290; n++) begin
            random_request();
            // Hold off once mid-phase until every response is back.
            if (phase == 2 && n == 140) drain();
         end
         drain();
      end

      $display("covered %0d requests (%0d schedules), %0d responses checked",
               requests_sent, schedules_sent, responses_seen);
      $display("bounds swept through reset, full range and inverted extremes");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("proportional_power_share_table_test: clean");
      else
         $display("proportional_power_share_table_test: errors");
      $finish;
   end

endmodule

`default_nettype wire
